// ===== rtl/ssui_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssui_pkg
// Shared types, op codes and the signed compare used by the set union /
// intersection engine and its element stores.
// ----------------------------------------------------------------------------
package ssui_pkg;

  localparam int unsigned ValueW      = 32;
  localparam int unsigned OpW         = 3;
  localparam int unsigned SetDepthDef = 16;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [OpW-1:0]           op_t;

  localparam op_t OpClear = 3'd0;
  localparam op_t OpAppA  = 3'd1;
  localparam op_t OpAppB  = 3'd2;
  localparam op_t OpUnion = 3'd3;
  localparam op_t OpInter = 3'd4;

  function automatic logic less_than(input value_t x, input value_t y);
    return x < y;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ssui_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssui_mem
// Element store for one set: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ssui_mem import ssui_pkg::*; #(
  parameter int unsigned Depth = SetDepthDef,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire value_t           wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output value_t                rdata_o
);

  value_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/sorted_set_union_intersection.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_set_union_intersection
// Two signed value sets with clear/append loads and union/intersection
// commands that sort both sets in place and stream the merged answer.
// ----------------------------------------------------------------------------
// Loads are written while idle. A command sorts A then B in place by selection sort
//   (load a candidate, compare it with the rest, write the minimum back), then merges.
// Throughput: one item at a time; busy_o stays high for the whole command,
//   set by the single read port of each store and the shared comparator.
// Results are strobed on valid_o for one cycle each; the receiver cannot stall.
// Reset clears counts, overflow flag and control; stores are undefined.
// ----------------------------------------------------------------------------
module sorted_set_union_intersection import ssui_pkg::*; #(
  parameter int unsigned SetDepth = SetDepthDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  output logic       busy_o,
  input  wire op_t   op_i,
  input  wire value_t value_i,
  output logic       valid_o,
  output value_t     value_res_o,
  output logic       last_o,
  output logic       empty_res_o,
  output logic       overflow_o
);

  localparam int unsigned CntW = $clog2(SetDepth + 1);
  localparam int unsigned IdxW = (SetDepth > 1) ? $clog2(SetDepth) : 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSortI = 3'd1;
  localparam logic [2:0] StLoad  = 3'd2;
  localparam logic [2:0] StCmp   = 3'd3;
  localparam logic [2:0] StWb    = 3'd4;
  localparam logic [2:0] StMrgRd = 3'd5;
  localparam logic [2:0] StMrg   = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic            drop_q, drop_d;
  logic            union_q, union_d;
  logic            selb_q, selb_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  logic [CntW-1:0] ia_q, ia_d, ib_q, ib_d;
  value_t          cur_q, cur_d;
  logic            pend_vld_q, pend_vld_d;
  value_t          pend_val_q, pend_val_d;
  logic            vld_q, vld_d;
  value_t          oval_q, oval_d;
  logic            last_q, last_d;
  logic            oemp_q, oemp_d;
  logic            oovf_q, oovf_d;

  logic            we_a, we_b;
  logic [IdxW-1:0] waddr;
  value_t          wdata;
  logic [IdxW-1:0] raddr_a, raddr_b;
  value_t          rdata_a, rdata_b;

  logic            sort_rd;
  logic [IdxW-1:0] sort_raddr;
  logic [CntW-1:0] n_sel, i_inc, j_inc;
  value_t          rd_sel, cmp_x, cmp_y;
  logic            cmp_lt, cmp_eq;
  logic            have_a, have_b, emit;
  value_t          emit_val;
  logic            merging;

  ssui_mem #(.Depth(SetDepth)) u_mem_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  ssui_mem #(.Depth(SetDepth)) u_mem_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  assign n_sel   = selb_q ? cnt_b_q : cnt_a_q;
  assign rd_sel  = selb_q ? rdata_b : rdata_a;
  assign i_inc   = i_q + CntW'(1);
  assign j_inc   = j_q + CntW'(1);
  assign merging = (state_q == StMrg);
  assign have_a  = (ia_q < cnt_a_q);
  assign have_b  = (ib_q < cnt_b_q);

  // shared comparator: sort compares s[j] against the held minimum,
  // merge compares head of B against head of A
  assign cmp_x  = merging ? rdata_b : rd_sel;
  assign cmp_y  = merging ? rdata_a : cur_q;
  assign cmp_lt = less_than(cmp_x, cmp_y);
  assign cmp_eq = (cmp_x == cmp_y);

  always_comb begin
    state_d    = state_q;
    cnt_a_d    = cnt_a_q;
    cnt_b_d    = cnt_b_q;
    drop_d     = drop_q;
    union_d    = union_q;
    selb_d     = selb_q;
    i_d        = i_q;
    j_d        = j_q;
    ia_d       = ia_q;
    ib_d       = ib_q;
    cur_d      = cur_q;
    pend_vld_d = pend_vld_q;
    pend_val_d = pend_val_q;
    vld_d      = 1'b0;
    oval_d     = oval_q;
    last_d     = last_q;
    oemp_d     = oemp_q;
    oovf_d     = oovf_q;
    we_a       = 1'b0;
    we_b       = 1'b0;
    waddr      = '0;
    wdata      = value_i;
    raddr_a    = ia_q[IdxW-1:0];
    raddr_b    = ib_q[IdxW-1:0];
    sort_rd    = 1'b0;
    sort_raddr = '0;
    emit       = 1'b0;
    emit_val   = rdata_a;

    case (state_q)
      StIdle: begin
        if (start_i) begin
          case (op_i)
            OpClear: begin
              cnt_a_d = '0;
              cnt_b_d = '0;
              drop_d  = 1'b0;
            end
            OpAppA: begin
              if (cnt_a_q < CntW'(SetDepth)) begin
                we_a    = 1'b1;
                waddr   = cnt_a_q[IdxW-1:0];
                cnt_a_d = cnt_a_q + CntW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            OpAppB: begin
              if (cnt_b_q < CntW'(SetDepth)) begin
                we_b    = 1'b1;
                waddr   = cnt_b_q[IdxW-1:0];
                cnt_b_d = cnt_b_q + CntW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            OpUnion, OpInter: begin
              union_d    = (op_i == OpUnion);
              selb_d     = 1'b0;
              i_d        = '0;
              pend_vld_d = 1'b0;
              state_d    = StSortI;
            end
            default: begin
            end
          endcase
        end
      end
      StSortI: begin
        if (i_inc >= n_sel) begin
          if (selb_q) begin
            ia_d    = '0;
            ib_d    = '0;
            state_d = StMrgRd;
          end else begin
            selb_d = 1'b1;
            i_d    = '0;
          end
        end else begin
          sort_rd    = 1'b1;
          sort_raddr = i_q[IdxW-1:0];
          j_d        = i_inc;
          state_d    = StLoad;
        end
      end
      StLoad: begin
        cur_d      = rd_sel;
        sort_rd    = 1'b1;
        sort_raddr = j_q[IdxW-1:0];
        state_d    = StCmp;
      end
      StCmp: begin
        if (cmp_lt) begin
          we_a  = !selb_q;
          we_b  = selb_q;
          waddr = j_q[IdxW-1:0];
          wdata = cur_q;
          cur_d = rd_sel;
        end
        j_d = j_inc;
        if (j_inc < n_sel) begin
          sort_rd    = 1'b1;
          sort_raddr = j_inc[IdxW-1:0];
        end else begin
          state_d = StWb;
        end
      end
      StWb: begin
        we_a    = !selb_q;
        we_b    = selb_q;
        waddr   = i_q[IdxW-1:0];
        wdata   = cur_q;
        i_d     = i_inc;
        state_d = StSortI;
      end
      StMrgRd: begin
        state_d = StMrg;
      end
      StMrg: begin
        state_d = StMrgRd;
        if (have_a && have_b) begin
          if (cmp_lt) begin
            emit     = union_q;
            emit_val = rdata_b;
            ib_d     = ib_q + CntW'(1);
          end else if (!cmp_eq) begin
            emit = union_q;
            ia_d = ia_q + CntW'(1);
          end else begin
            emit = 1'b1;
            ia_d = ia_q + CntW'(1);
            ib_d = ib_q + CntW'(1);
          end
        end else if (union_q && have_a) begin
          emit = 1'b1;
          ia_d = ia_q + CntW'(1);
        end else if (union_q && have_b) begin
          emit     = 1'b1;
          emit_val = rdata_b;
          ib_d     = ib_q + CntW'(1);
        end else begin
          // flush the held element as the final transfer, or report empty
          vld_d   = 1'b1;
          last_d  = 1'b1;
          oovf_d  = drop_q;
          oemp_d  = !pend_vld_q;
          oval_d  = pend_vld_q ? pend_val_q : '0;
          state_d = StIdle;
        end
        if (emit) begin
          pend_vld_d = 1'b1;
          pend_val_d = emit_val;
          if (pend_vld_q) begin
            vld_d  = 1'b1;
            oval_d = pend_val_q;
            last_d = 1'b0;
            oemp_d = 1'b0;
            oovf_d = drop_q;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (sort_rd) begin
      if (selb_q) begin
        raddr_b = sort_raddr;
      end else begin
        raddr_a = sort_raddr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      drop_q     <= 1'b0;
      union_q    <= 1'b0;
      selb_q     <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      ia_q       <= '0;
      ib_q       <= '0;
      pend_vld_q <= 1'b0;
      vld_q      <= 1'b0;
      last_q     <= 1'b0;
      oemp_q     <= 1'b0;
      oovf_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_a_q    <= cnt_a_d;
      cnt_b_q    <= cnt_b_d;
      drop_q     <= drop_d;
      union_q    <= union_d;
      selb_q     <= selb_d;
      i_q        <= i_d;
      j_q        <= j_d;
      ia_q       <= ia_d;
      ib_q       <= ib_d;
      pend_vld_q <= pend_vld_d;
      vld_q      <= vld_d;
      last_q     <= last_d;
      oemp_q     <= oemp_d;
      oovf_q     <= oovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    pend_val_q <= pend_val_d;
    oval_q     <= oval_d;
  end

  assign busy_o      = (state_q != StIdle);
  assign valid_o     = vld_q;
  assign value_res_o = oval_q;
  assign last_o      = last_q;
  assign empty_res_o = oemp_q;
  assign overflow_o  = oovf_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CntW'(SetDepth)) && (cnt_b_q <= CntW'(SetDepth)))
    else $error("set count beyond depth");

  a_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && ((op_i == OpUnion) || (op_i == OpInter))) |=> busy_o)
    else $error("command accepted without going busy");

  a_sort_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StLoad) || (state_q == StCmp)) |->
    (i_q < n_sel) && (j_q < n_sel))
    else $error("sort index out of range");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && empty_res_o) |-> (last_o && (value_res_o == '0) && !pend_vld_q))
    else $error("empty transfer malformed");

  a_result_from_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == StMrg))
    else $error("transfer outside merge");

endmodule
`default_nettype wire

// ===== dv/tb_sorted_set_union_intersection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_set_union_intersection
// Self-checking bench for the sorted set union / intersection engine. A short
// table of directed loads and commands runs first: extremes, duplicates,
// unused op codes and empty answers. Random clear/append/command sequences
// follow, with set sizes up to past the full mark. Every accepted item updates
// a bench-side copy of both sets, and each strobed result is compared field
// by field with the oldest predicted answer element.
// ----------------------------------------------------------------------------
module tb_sorted_set_union_intersection;
  import ssui_pkg::*;

  localparam int   StallLimit = 4000;
  localparam int   NumItems   = 450;
  localparam int   QuietFrom  = 390;
  localparam int   NumRows    = 23;
  localparam op_t  OpRsvd5    = 3'd5;
  localparam op_t  OpRsvd6    = 3'd6;
  localparam op_t  OpRsvd7    = 3'd7;

  typedef struct packed {
    value_t val;
    logic   last;
    logic   empty;
    logic   ovf;
  } set_result_t;

  typedef struct packed {
    op_t         op;
    value_t      val;
    logic        typed;
    set_result_t res;
  } stim_row_t;

  typedef value_t store_t [SetDepthDef];

  logic   clk_i;
  logic   rst_ni;
  logic   start_i;
  logic   busy_o;
  op_t    op_i;
  value_t value_i;
  logic   valid_o;
  value_t value_res_o;
  logic   last_o;
  logic   empty_res_o;
  logic   overflow_o;

  logic        typed_valid;
  set_result_t typed_res;

  store_t      a_store;
  store_t      b_store;
  int          count_a;
  int          count_b;
  logic        dropped;
  set_result_t merge_out[$];
  set_result_t pending_answers[$];

  int mismatches;
  int stall_cycles;
  int items_sent;
  bit no_idle;

  stim_row_t directed_rows [NumRows] = '{
    '{OpUnion, 32'sh0000_0000, 1'b1, '{32'sh0, 1'b1, 1'b1, 1'b0}},
    '{OpInter, 32'sh1234_5678, 1'b1, '{32'sh0, 1'b1, 1'b1, 1'b0}},
    '{OpRsvd5, 32'shFFFF_FFFF, 1'b0, '0},
    '{OpRsvd6, 32'sh0000_0000, 1'b0, '0},
    '{OpRsvd7, 32'shA5A5_A5A5, 1'b0, '0},
    '{OpAppA,  32'sh7FFF_FFFF, 1'b0, '0},
    '{OpAppA,  32'sh8000_0000, 1'b0, '0},
    '{OpAppA,  32'sh0000_0000, 1'b0, '0},
    '{OpAppA,  32'sh0000_0000, 1'b0, '0},
    '{OpAppB,  32'sh8000_0000, 1'b0, '0},
    '{OpAppB,  32'shFFFF_FFFF, 1'b0, '0},
    '{OpAppB,  32'sh0000_0000, 1'b0, '0},
    '{OpUnion, 32'sh5A5A_5A5A, 1'b0, '0},
    '{OpInter, 32'sh0000_0000, 1'b0, '0},
    '{OpUnion, 32'sh0000_0000, 1'b0, '0},
    '{OpClear, 32'shFFFF_FFFF, 1'b0, '0},
    '{OpAppA,  32'sh7FFF_FFFF, 1'b0, '0},
    '{OpInter, 32'sh0000_0000, 1'b1, '{32'sh0, 1'b1, 1'b1, 1'b0}},
    '{OpUnion, 32'sh0000_0000, 1'b1, '{32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b0}},
    '{OpAppB,  32'sh7FFF_FFFF, 1'b0, '0},
    '{OpInter, 32'sh0000_0000, 1'b1, '{32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b0}},
    '{OpClear, 32'sh0000_0000, 1'b0, '0},
    '{OpUnion, 32'sh0000_0000, 1'b1, '{32'sh0, 1'b1, 1'b1, 1'b0}}
  };

  sorted_set_union_intersection u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .valid_o     (valid_o),
    .value_res_o (value_res_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o),
    .overflow_o  (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic store_t sorted_copy(input store_t s, input int n);
    value_t t;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (s[j] < s[i]) begin
          t    = s[i];
          s[i] = s[j];
          s[j] = t;
        end
      end
    end
    return s;
  endfunction

  task automatic compute_set_answer(input op_t op, input value_t v);
    store_t sa;
    store_t sb;
    int     ia;
    int     ib;
    bit     is_union;
    merge_out.delete();
    case (op)
      OpClear: begin
        count_a = 0;
        count_b = 0;
        dropped = 1'b0;
      end
      OpAppA: begin
        if (count_a < SetDepthDef) begin
          a_store[count_a] = v;
          count_a++;
        end else begin
          dropped = 1'b1;
        end
      end
      OpAppB: begin
        if (count_b < SetDepthDef) begin
          b_store[count_b] = v;
          count_b++;
        end else begin
          dropped = 1'b1;
        end
      end
      OpUnion, OpInter: begin
        is_union = (op == OpUnion);
        sa = sorted_copy(a_store, count_a);
        sb = sorted_copy(b_store, count_b);
        ia = 0;
        ib = 0;
        while (ia < count_a && ib < count_b) begin
          if (sb[ib] < sa[ia]) begin
            if (is_union) merge_out.push_back('{sb[ib], 1'b0, 1'b0, dropped});
            ib++;
          end else if (sa[ia] < sb[ib]) begin
            if (is_union) merge_out.push_back('{sa[ia], 1'b0, 1'b0, dropped});
            ia++;
          end else begin
            merge_out.push_back('{sa[ia], 1'b0, 1'b0, dropped});
            ia++;
            ib++;
          end
        end
        if (is_union) begin
          for (; ia < count_a; ia++) merge_out.push_back('{sa[ia], 1'b0, 1'b0, dropped});
          for (; ib < count_b; ib++) merge_out.push_back('{sb[ib], 1'b0, 1'b0, dropped});
        end
        if (merge_out.size() == 0) begin
          merge_out.push_back('{32'sh0, 1'b1, 1'b1, dropped});
        end else begin
          merge_out[merge_out.size()-1].last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i) begin : monitor
    set_result_t got;
    set_result_t want;
    if (rst_ni) begin
      if (valid_o) begin
        got = '{value_res_o, last_o, empty_res_o, overflow_o};
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual val=%0d last=%0b empty=%0b ovf=%0b",
                   $time, got.val, got.last, got.empty, got.ovf);
          mismatches++;
        end else begin
          want = pending_answers.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected val=%0d last=%0b empty=%0b ovf=%0b",
                     $time, want.val, want.last, want.empty, want.ovf);
            $display("%0t:           actual   val=%0d last=%0b empty=%0b ovf=%0b",
                     $time, got.val, got.last, got.empty, got.ovf);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_o) begin
        compute_set_answer(op_i, value_i);
        if (typed_valid) begin
          pending_answers.push_back(typed_res);
        end else begin
          foreach (merge_out[k]) pending_answers.push_back(merge_out[k]);
        end
      end
      if ((start_i && !busy_o) || valid_o) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  function automatic value_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return value_t'($urandom_range(0, 7)) - 4;
    if (r == 5) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7FFF_FFFF;
        2:       return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return value_t'($urandom);
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 6);
    if (r < 9) return $urandom_range(7, SetDepthDef);
    return $urandom_range(SetDepthDef + 1, SetDepthDef + 4);
  endfunction

  task automatic send_item(input op_t op, input value_t v, input logic tv,
                           input set_result_t tr);
    start_i     <= 1'b1;
    op_i        <= op;
    value_i     <= v;
    typed_valid <= tv;
    typed_res   <= tr;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (op <= OpInter) items_sent++;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic send_plain(input op_t op, input value_t v);
    send_item(op, v, 1'b0, '0);
  endtask

  task automatic drain_answers();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int na;
    int nb;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    op_i         = OpClear;
    value_i      = '0;
    typed_valid  = 1'b0;
    typed_res    = '0;
    count_a      = 0;
    count_b      = 0;
    dropped      = 1'b0;
    mismatches   = 0;
    stall_cycles = 0;
    items_sent   = 0;
    no_idle      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].val, directed_rows[i].typed,
                directed_rows[i].res);
    end
    drain_answers();

    while (items_sent < NumItems) begin
      no_idle = (items_sent >= QuietFrom) || ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_plain(op_t'($urandom_range(OpRsvd5, OpRsvd7)), value_t'($urandom));
        end
      end else begin
        if ($urandom_range(0, 5) != 0) send_plain(OpClear, value_t'($urandom));
        na = pick_size();
        nb = pick_size();
        while (na + nb > 0) begin
          if ($urandom_range(0, 19) == 0) begin
            send_plain($urandom_range(0, 1) ? OpUnion : OpInter, value_t'($urandom));
          end
          if (nb == 0 || (na > 0 && $urandom_range(0, 1) == 0)) begin
            send_plain(OpAppA, pick_value());
            na--;
          end else begin
            send_plain(OpAppB, pick_value());
            nb--;
          end
        end
        repeat ($urandom_range(1, 2)) begin
          send_plain($urandom_range(0, 1) ? OpUnion : OpInter, value_t'($urandom));
        end
        if ($urandom_range(0, 7) == 0) drain_answers();
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (pending_answers.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_answers.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
